// ===== design/vapc_pkg.sv =====
// vapc_pkg: shared widths, codes, types and helpers for the vector axis/plane
// constraint block. No dependencies; imported by the interfaces and the top level.

package vapc_pkg;

  localparam int VEC_W      = 32;  // signed Q16.16 vector component
  localparam int QUAT_W     = 16;  // signed Q1.14 quaternion part
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_Q_W   = 32;  // product of two quaternion parts
  localparam int ROT_W      = 31;  // rotation matrix entry, signed Q4.27
  localparam int PROD_W     = 63;  // matrix entry times vector component
  localparam int ACC_W      = 64;
  localparam int MID_W      = 34;  // frame-local component, clamped to +/-2^32
  localparam int FRAC_SH    = 27;
  localparam int NSTG       = 8;   // pipeline register stages

  typedef logic signed [VEC_W-1:0]  comp_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [MID_W-1:0]  mid_t;

  // constraint modes
  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AXIS_X  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AXIS_Y  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AXIS_Z  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PLANE_X = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PLANE_Y = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PLANE_Z = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_W      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SIGN  = 3'd6;

  localparam quat_t QUAT_ONE     = 16'sd16384;
  localparam quat_t QUAT_NEG_ONE = -16'sd16384;
  localparam quat_t QUAT_ZERO    = 16'sd0;

  localparam logic signed [PROD_Q_W-1:0] Q27_ONE = 32'sd134217728;
  localparam acc_t Q27_HALF  = 64'sd67108864;
  localparam acc_t MID_POS   = 64'sd4294967296;
  localparam acc_t MID_NEG   = -64'sd4294967296;
  localparam acc_t OUT_POS   = 64'sd2147483647;
  localparam acc_t OUT_NEG   = -64'sd2147483648;

  function automatic quat_t clamp_quat(input quat_t a);
    quat_t res;
    if (a > QUAT_ONE) begin
      res = QUAT_ONE;
    end else if (a < QUAT_NEG_ONE) begin
      res = QUAT_NEG_ONE;
    end else begin
      res = a;
    end
    return res;
  endfunction

endpackage

// ===== design/vapc_if.sv =====
// vapc_if: valid/ready channel interfaces for vector input and constrained output.
// Depends on vapc_pkg for the component type.

interface vapc_in_if
  import vapc_pkg::*;
;
  logic  valid;
  logic  ready;
  comp_t vec_x;
  comp_t vec_y;
  comp_t vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface vapc_out_if
  import vapc_pkg::*;
;
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

// ===== design/vector_axis_plane_constraint.sv =====
// vector_axis_plane_constraint: pipelined axis/plane constraint of a Q16.16 vector
// in a world or quaternion frame. Depends on vapc_pkg and the vapc_if interfaces.
//
// Usage:
//   in_if  (sink)   : one vector (vec_x, vec_y, vec_z) per transaction.
//   out_if (source) : one constrained, saturated vector (out_x, out_y, out_z)
//                     per input transaction, in input order.
//   cfg_*           : write port; cfg_index selects the register, data in cfg_wdata.
//                     write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_if.ready is high. Eight
//   register stages: input, mode decode, unrotate multiply, unrotate sum,
//   round/clamp/mask, rotate multiply, rotate sum, round/saturate output.
// The rotation matrix is rebuilt from the quaternion registers every cycle and
//   is registered after them, so a write reaches it through that register.
// Reset (rst_n low, synchronous) empties the pipeline and restores mode none,
//   world frame and the identity quaternion.
// Stall: each stage holds while the stage after it is full and stalled; empty
//   stages still fill, so in_if.ready drops only once all stages are full.

module vector_axis_plane_constraint
  import vapc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vapc_in_if.sink               in_if,
  vapc_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [MODE_W-1:0] mode_r;
  logic              local_r;
  quat_t             qw_r, qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      local_r <= 1'b0;
      qw_r    <= QUAT_ONE;
      qx_r    <= QUAT_ZERO;
      qy_r    <= QUAT_ZERO;
      qz_r    <= QUAT_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_LOCAL: local_r <= cfg_wdata[0];
        CFG_ROT_W: qw_r    <= clamp_quat(quat_t'(cfg_wdata));
        CFG_ROT_X: qx_r    <= clamp_quat(quat_t'(cfg_wdata));
        CFG_ROT_Y: qy_r    <= clamp_quat(quat_t'(cfg_wdata));
        CFG_ROT_Z: qz_r    <= clamp_quat(quat_t'(cfg_wdata));
        // axis sign cancels in the projection, nothing to store
        CFG_AXIS_SIGN: ;
        default: ;
      endcase
    end
  end

  // rotation matrix, Q4.27
  quat_t w, x, y, z;
  logic signed [PROD_Q_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  rot_t rot_nxt [3][3];
  rot_t rot_r   [3][3];

  always_comb begin
    w = local_r ? qw_r : QUAT_ONE;
    x = local_r ? qx_r : QUAT_ZERO;
    y = local_r ? qy_r : QUAT_ZERO;
    z = local_r ? qz_r : QUAT_ZERO;
    xx = x * x;  yy = y * y;  zz = z * z;
    xy = x * y;  xz = x * z;  yz = y * z;
    wx = w * x;  wy = w * y;  wz = w * z;
    rot_nxt[0][0] = ROT_W'(Q27_ONE - (yy + zz));
    rot_nxt[0][1] = ROT_W'(xy - wz);
    rot_nxt[0][2] = ROT_W'(xz + wy);
    rot_nxt[1][0] = ROT_W'(xy + wz);
    rot_nxt[1][1] = ROT_W'(Q27_ONE - (xx + zz));
    rot_nxt[1][2] = ROT_W'(yz - wx);
    rot_nxt[2][0] = ROT_W'(xz - wy);
    rot_nxt[2][1] = ROT_W'(yz + wx);
    rot_nxt[2][2] = ROT_W'(Q27_ONE - (xx + yy));
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_if.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_if.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_if.ready = rdy[0];

  // stage 0: input register
  comp_t s0_vec_r [3];
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_vec_r[0] <= in_if.vec_x;
      s0_vec_r[1] <= in_if.vec_y;
      s0_vec_r[2] <= in_if.vec_z;
    end
  end

  // stage 1: mode decode into keep mask and bypass flag
  comp_t      s1_vec_r [3];
  logic [2:0] s1_keep_r;
  logic       s1_pass_r;
  logic [2:0] keep_nxt;
  logic       pass_nxt;

  always_comb begin
    keep_nxt = 3'b000;
    pass_nxt = 1'b0;
    unique case (mode_r)
      MODE_AXIS_X:  keep_nxt = 3'b001;
      MODE_AXIS_Y:  keep_nxt = 3'b010;
      MODE_AXIS_Z:  keep_nxt = 3'b100;
      MODE_PLANE_X: keep_nxt = 3'b110;
      MODE_PLANE_Y: keep_nxt = 3'b101;
      MODE_PLANE_Z: keep_nxt = 3'b011;
      // mode none and the unused code pass the vector through
      default:      pass_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_vec_r  <= s0_vec_r;
      s1_keep_r <= keep_nxt;
      s1_pass_r <= pass_nxt;
    end
  end

  // stage 2: unrotate products, p[i][j] = R[i][j] * v[i]
  comp_t      s2_vec_r [3];
  logic [2:0] s2_keep_r;
  logic       s2_pass_r;
  prod_t      s2_prod_r [3][3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_vec_r  <= s1_vec_r;
      s2_keep_r <= s1_keep_r;
      s2_pass_r <= s1_pass_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s2_prod_r[i][j] <= PROD_W'(rot_r[i][j] * s1_vec_r[i]);
        end
      end
    end
  end

  // stage 3: unrotate sums with rounding offset
  comp_t      s3_vec_r [3];
  logic [2:0] s3_keep_r;
  logic       s3_pass_r;
  acc_t       s3_acc_r [3];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_vec_r  <= s2_vec_r;
      s3_keep_r <= s2_keep_r;
      s3_pass_r <= s2_pass_r;
      for (int j = 0; j < 3; j++) begin
        s3_acc_r[j] <= ACC_W'(s2_prod_r[0][j]) + ACC_W'(s2_prod_r[1][j])
                     + ACC_W'(s2_prod_r[2][j]) + Q27_HALF;
      end
    end
  end

  // stage 4: round, clamp to +/-2^32, mask in the frame
  comp_t s4_vec_r [3];
  logic  s4_pass_r;
  mid_t  s4_u_r [3];
  mid_t  u_nxt [3];
  acc_t  shr [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shr[j] = s3_acc_r[j] >>> FRAC_SH;
      if (!s3_keep_r[j]) begin
        u_nxt[j] = '0;
      end else if (shr[j] > MID_POS) begin
        u_nxt[j] = MID_W'(MID_POS);
      end else if (shr[j] < MID_NEG) begin
        u_nxt[j] = MID_W'(MID_NEG);
      end else begin
        u_nxt[j] = MID_W'(shr[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_vec_r  <= s3_vec_r;
      s4_pass_r <= s3_pass_r;
      s4_u_r    <= u_nxt;
    end
  end

  // stage 5: rotate-back products, q[i][j] = R[i][j] * u[j]
  comp_t s5_vec_r [3];
  logic  s5_pass_r;
  prod_t s5_prod_r [3][3];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_vec_r  <= s4_vec_r;
      s5_pass_r <= s4_pass_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // |R*u| <= 2^61, fits the product width
          s5_prod_r[i][j] <= PROD_W'(rot_r[i][j] * s4_u_r[j]);
        end
      end
    end
  end

  // stage 6: rotate-back sums with rounding offset
  comp_t s6_vec_r [3];
  logic  s6_pass_r;
  acc_t  s6_acc_r [3];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_vec_r  <= s5_vec_r;
      s6_pass_r <= s5_pass_r;
      for (int i = 0; i < 3; i++) begin
        s6_acc_r[i] <= ACC_W'(s5_prod_r[i][0]) + ACC_W'(s5_prod_r[i][1])
                     + ACC_W'(s5_prod_r[i][2]) + Q27_HALF;
      end
    end
  end

  // stage 7: round, saturate, select bypass
  comp_t res_nxt [3];
  comp_t res_r   [3];
  acc_t  shr_out [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr_out[i] = s6_acc_r[i] >>> FRAC_SH;
      if (s6_pass_r) begin
        res_nxt[i] = s6_vec_r[i];
      end else if (shr_out[i] > OUT_POS) begin
        res_nxt[i] = VEC_W'(OUT_POS);
      end else if (shr_out[i] < OUT_NEG) begin
        res_nxt[i] = VEC_W'(OUT_NEG);
      end else begin
        res_nxt[i] = VEC_W'(shr_out[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid = vld_r[NSTG-1];
  assign out_if.out_x = res_r[0];
  assign out_if.out_y = res_r[1];
  assign out_if.out_z = res_r[2];

`ifndef SYNTHESIS
  // a taken transaction always lands in the input stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> vld_r[0])
    else $error("accepted transaction missing from input stage");

  // a free output means the whole pipeline can advance
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.ready |-> in_if.ready)
    else $error("input stalled while output is free");

  // a stalled rotate-sum stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] && !rdy[6] |=> vld_r[6])
    else $error("stalled stage lost its item");

  // frame-local components stay inside the intermediate clamp
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (ACC_W'(s4_u_r[0]) <= MID_POS) && (ACC_W'(s4_u_r[0]) >= MID_NEG)
              && (ACC_W'(s4_u_r[1]) <= MID_POS) && (ACC_W'(s4_u_r[1]) >= MID_NEG)
              && (ACC_W'(s4_u_r[2]) <= MID_POS) && (ACC_W'(s4_u_r[2]) >= MID_NEG))
    else $error("intermediate component out of range");
`endif

endmodule
